// ----- src/catmull_rom_keyframe_path_core_assert.svh -----
// Assertion macros for the keyframe path core
`ifndef CATMULL_ROM_KEYFRAME_PATH_CORE_ASSERT_SVH
`define CATMULL_ROM_KEYFRAME_PATH_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CRK_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define CRK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- src/crk_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crk_pkg
// Types and constants shared by the keyframe path core.
// ---------------------------------------------------------------------------
package crk_pkg;
	localparam int MAX_KEYS_DEF = 64;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_QUERY  = 3'd2;
	localparam logic [2:0] CMD_START  = 3'd3;
	localparam logic [2:0] CMD_STOP   = 3'd4;
	localparam logic [2:0] CMD_TICK   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [31:0]        time_value;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [5:0]         key_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               position_valid;
		logic               playing;
		logic [1:0]         status;
		logic [6:0]         key_count;
	} rsp_t;
endpackage

// ----- src/catmull_rom_keyframe_path_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// catmull_rom_keyframe_path_core
// Sorted keyframe store in one memory with Catmull-Rom evaluation.
// ---------------------------------------------------------------------------
// Requests are taken one at a time, the cycle after the previous response leaves;
// during a query or tick the segment walk, the serial divider and the blend keep it busy.
// Reset clears key count, play time and playback; the key memory is
// undefined until written and needs no clearing pass.
`include "catmull_rom_keyframe_path_core_assert.svh"
module catmull_rom_keyframe_path_core #(
	parameter int MAX_KEYS = crk_pkg::MAX_KEYS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  crk_pkg::req_t in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output crk_pkg::rsp_t out_data
);
	import crk_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_SHUP = 4'd2;
	localparam logic [3:0] S_SHDN = 4'd3;
	localparam logic [3:0] S_FIND = 4'd4;
	localparam logic [3:0] S_FETCH = 4'd5;
	localparam logic [3:0] S_DIV = 4'd6;
	localparam logic [3:0] S_MUL = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_LAST = 4'd9;

	typedef struct packed {
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} key_t;

	key_t mem [MAX_KEYS];
	key_t rd_q;
	logic [AW-1:0] ra;
	logic          re;
	logic [AW-1:0] wa;
	logic          we;
	key_t          wd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [31:0]   ptime_q;
	logic          pact_q;
	req_t          req_q;
	rsp_t          rsp_q;
	logic          ov_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] pos_q;
	logic          rv_q;
	logic [31:0]   t_q;
	logic [31:0]   t0_q;
	logic [2:0]    fi_q;
	key_t          k_q [4];
	logic [47:0]   num_q;
	logic [31:0]   den_q;
	logic [47:0]   rem_q;
	logic [5:0]    dc_q;
	logic [16:0]   u_q;
	logic [1:0]    ax_q;
	logic [1:0]    ph_q;
	logic signed [65:0] r_q;
	logic signed [31:0] res_q [3];

	logic [CW-1:0] seg_q;

	assign in_stall = (state_q != S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign out_data = rsp_q;

	logic signed [33:0] p0, p1, p2, p3;
	logic signed [65:0] c3, c2, c1, c0, cadd, prod;
	logic signed [65:0] rsh;
	logic signed [31:0] sat;
	logic [48:0] trial;

	always_comb begin
		case (ax_q)
			2'd0: begin
				p0 = 34'(signed'(k_q[0].x)); p1 = 34'(signed'(k_q[1].x));
				p2 = 34'(signed'(k_q[2].x)); p3 = 34'(signed'(k_q[3].x));
			end
			2'd1: begin
				p0 = 34'(signed'(k_q[0].y)); p1 = 34'(signed'(k_q[1].y));
				p2 = 34'(signed'(k_q[2].y)); p3 = 34'(signed'(k_q[3].y));
			end
			default: begin
				p0 = 34'(signed'(k_q[0].z)); p1 = 34'(signed'(k_q[1].z));
				p2 = 34'(signed'(k_q[2].z)); p3 = 34'(signed'(k_q[3].z));
			end
		endcase
		c3 = 66'(-p0 + 3 * p1 - 3 * p2 + p3);
		c2 = 66'(2 * p0 - 5 * p1 + 4 * p2 - p3);
		c1 = 66'(p2 - p0);
		c0 = 66'(2 * p1);
		case (ph_q)
			2'd0: cadd = c2;
			2'd1: cadd = c1;
			default: cadd = c0;
		endcase
		prod = 66'($signed(r_q[37:0]) * $signed({1'b0, u_q}));
		prod = prod >>> 16;
		rsh = r_q >>> 1;
		if (rsh > 66'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (rsh < -66'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = rsh[31:0];
		end
		trial = {rem_q, num_q[47]} - {17'd0, den_q};
	end

	logic [31:0] sum_t;
	logic        sum_c;
	assign {sum_c, sum_t} = {1'b0, ptime_q} + {1'b0, req_q.time_value};

	logic [1:0] acc_st;
	always_comb begin
		acc_st = ST_OK;
		case (in_data.cmd)
			CMD_INSERT: begin
				if (count_q >= CW'(MAX_KEYS)) begin
					acc_st = ST_FULL;
				end
			end
			CMD_DELETE: begin
				if (count_q == '0) begin
					acc_st = ST_EMPTY;
				end else if (32'(in_data.key_index) >= 32'(count_q)) begin
					acc_st = ST_RANGE;
				end
			end
			CMD_QUERY: begin
				if (count_q == '0) begin
					acc_st = ST_EMPTY;
				end
			end
			CMD_TICK: begin
				if (pact_q && count_q == '0) begin
					acc_st = ST_EMPTY;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptime_q <= '0;
			pact_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q <= in_data;
						rsp_q <= '{out_x: '0, out_y: '0, out_z: '0, position_valid: 1'b0,
							playing: 1'b0, status: acc_st, key_count: '0};
						i_q <= (in_data.cmd == CMD_DELETE) ? CW'(in_data.key_index) : '0;
						rv_q <= 1'b0;
						fi_q <= '0;
						pos_q <= count_q;
						t_q <= in_data.time_value;
						case (in_data.cmd)
							CMD_INSERT: begin
								if (count_q >= CW'(MAX_KEYS)) begin
									state_q <= S_LAST;
								end else begin
									state_q <= S_SRCH;
								end
							end
							CMD_DELETE: begin
								if (count_q == '0) begin
									state_q <= S_LAST;
								end else if (32'(in_data.key_index) >= 32'(count_q)) begin
									state_q <= S_LAST;
								end else begin
									state_q <= S_SHDN;
								end
							end
							CMD_QUERY: begin
								if (count_q == '0) begin
									state_q <= S_LAST;
								end else begin
									state_q <= S_FIND;
								end
							end
							CMD_START: begin
								ptime_q <= in_data.time_value;
								pact_q <= 1'b1;
								state_q <= S_LAST;
							end
							CMD_STOP: begin
								ptime_q <= '0;
								pact_q <= 1'b0;
								state_q <= S_LAST;
							end
							CMD_TICK: begin
								if (!pact_q) begin
									state_q <= S_LAST;
								end else if (count_q == '0) begin
									pact_q <= 1'b0;
									state_q <= S_LAST;
								end else begin
									state_q <= S_FIND;
								end
							end
							default: state_q <= S_LAST;
						endcase
					end
				end
				S_SRCH: begin
					// find first key with time greater than new key
					if (rv_q) begin
						rv_q <= 1'b0;
						if (rd_q.t > req_q.time_value) begin
							pos_q <= i_q;
							i_q <= count_q;
							state_q <= S_SHUP;
						end else if (i_q + 1'b1 >= count_q) begin
							i_q <= count_q;
							state_q <= S_SHUP;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else if (i_q >= count_q) begin
						i_q <= count_q;
						state_q <= S_SHUP;
					end else begin
						rv_q <= 1'b1;
					end
				end
				S_SHUP: begin
					if (rv_q) begin
						rv_q <= 1'b0;
						i_q <= i_q - 1'b1;
					end else if (i_q > pos_q) begin
						rv_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_LAST;
					end
				end
				S_SHDN: begin
					if (rv_q) begin
						rv_q <= 1'b0;
						i_q <= i_q + 1'b1;
					end else if (i_q + 1'b1 < count_q) begin
						rv_q <= 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_LAST;
					end
				end
				S_FIND: begin
					// read first and last key, then walk segments
					if (fi_q == 3'd0 && !rv_q) begin
						if (req_q.cmd == CMD_TICK) begin
							t_q <= sum_c ? 32'hffffffff : sum_t;
							ptime_q <= sum_c ? 32'hffffffff : sum_t;
						end
						rv_q <= 1'b1;
					end else if (fi_q == 3'd0) begin
						t0_q <= rd_q.t;
						k_q[0] <= rd_q;
						fi_q <= 3'd1;
					end else if (fi_q == 3'd1) begin
						fi_q <= 3'd2;
					end else if (fi_q == 3'd2) begin
						rv_q <= 1'b0;
						if (req_q.cmd == CMD_TICK && t_q > rd_q.t) begin
							ptime_q <= '0;
							pact_q <= 1'b0;
							state_q <= S_LAST;
						end else if (req_q.cmd == CMD_TICK && t_q < t0_q) begin
							state_q <= S_LAST;
						end else if (t_q < t0_q) begin
							res_q[0] <= k_q[0].x; res_q[1] <= k_q[0].y;
							res_q[2] <= k_q[0].z;
							rsp_q.position_valid <= 1'b1;
							state_q <= S_DONE;
						end else if (t_q >= rd_q.t) begin
							res_q[0] <= rd_q.x; res_q[1] <= rd_q.y;
							res_q[2] <= rd_q.z;
							rsp_q.position_valid <= 1'b1;
							state_q <= S_DONE;
						end else begin
							i_q <= '0;
							seg_q <= '0;
							state_q <= S_FETCH;
							fi_q <= 3'd4;
						end
					end
				end
				S_FETCH: begin
					// walk to segment, then load four neighbors
					if (fi_q == 3'd4) begin
						if (rv_q) begin
							rv_q <= 1'b0;
							if (rd_q.t > t_q) begin
								seg_q <= i_q - 1'b1;
								fi_q <= 3'd0;
								i_q <= '0;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							rv_q <= 1'b1;
						end
					end else if (rv_q) begin
						rv_q <= 1'b0;
						k_q[fi_q[1:0]] <= rd_q;
						if (fi_q == 3'd3) begin
							num_q <= {t_q - k_q[1].t, 16'd0};
							den_q <= k_q[2].t - k_q[1].t;
							rem_q <= '0;
							dc_q <= '0;
							state_q <= S_DIV;
						end else begin
							fi_q <= fi_q + 1'b1;
						end
					end else begin
						rv_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (!trial[48]) begin
						rem_q <= trial[47:0];
					end else begin
						rem_q <= {rem_q[46:0], num_q[47]};
					end
					num_q <= {num_q[46:0], ~trial[48]};
					dc_q <= dc_q + 1'b1;
					if (dc_q == 6'd47) begin
						u_q <= {1'b0, num_q[14:0], ~trial[48]};
						ax_q <= '0;
						ph_q <= '0;
						r_q <= '0;
						fi_q <= 3'd0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (fi_q == 3'd0) begin
						r_q <= c3;
						fi_q <= 3'd1;
					end else begin
						r_q <= prod + cadd;
						if (ph_q == 2'd2) begin
							ph_q <= 2'd3;
						end else if (ph_q == 2'd3) begin
							res_q[ax_q] <= sat;
							ph_q <= '0;
							fi_q <= 3'd0;
							if (ax_q == 2'd2) begin
								rsp_q.position_valid <= 1'b1;
								state_q <= S_DONE;
							end else begin
								ax_q <= ax_q + 1'b1;
							end
						end else begin
							ph_q <= ph_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					rsp_q.out_x <= res_q[0];
					rsp_q.out_y <= res_q[1];
					rsp_q.out_z <= res_q[2];
					state_q <= S_LAST;
				end
				S_LAST: begin
					rsp_q.playing <= pact_q;
					rsp_q.key_count <= 7'(count_q);
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memory port control
	logic [CW-1:0] im1, ip2;
	always_comb begin
		re = 1'b0;
		we = 1'b0;
		ra = '0;
		wa = '0;
		wd = rd_q;
		im1 = (seg_q == '0) ? '0 : seg_q - 1'b1;
		ip2 = (seg_q + 2'd2 < count_q) ? seg_q + 2'd2 : count_q - 1'b1;
		case (state_q)
			S_SRCH: begin
				re = !rv_q;
				ra = i_q[AW-1:0];
			end
			S_SHUP: begin
				if (!rv_q && i_q > pos_q) begin
					re = 1'b1;
					ra = AW'(i_q - 1'b1);
				end else if (rv_q) begin
					we = 1'b1;
					wa = i_q[AW-1:0];
				end else begin
					we = 1'b1;
					wa = pos_q[AW-1:0];
					wd = '{req_q.time_value, req_q.key_x, req_q.key_y, req_q.key_z};
				end
			end
			S_SHDN: begin
				if (!rv_q && i_q + 1'b1 < count_q) begin
					re = 1'b1;
					ra = AW'(i_q + 1'b1);
				end else if (rv_q) begin
					we = 1'b1;
					wa = i_q[AW-1:0];
				end
			end
			S_FIND: begin
				re = 1'b1;
				ra = (fi_q == 3'd0) ? '0 : AW'(count_q - 1'b1);
			end
			S_FETCH: begin
				re = !rv_q;
				case (fi_q)
					3'd0: ra = im1[AW-1:0];
					3'd1: ra = seg_q[AW-1:0];
					3'd2: ra = AW'(seg_q + 1'b1);
					3'd3: ra = ip2[AW-1:0];
					default: ra = i_q[AW-1:0];
				endcase
			end
			default: ;
		endcase
	end

	`CRK_ASSERT_IMP(a_cnt_max, 1'b1, count_q <= CW'(MAX_KEYS))
	`CRK_ASSERT_IMP(a_stall_busy, state_q != S_IDLE, in_stall)
	`CRK_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

// ----- test/tb_catmull_rom_keyframe_path_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_catmull_rom_keyframe_path_core
// Self-checking bench: drives insert, delete, query and playback requests,
// predicts each response with a local keyframe path model, compares fields.
// ---------------------------------------------------------------------------
module tb_catmull_rom_keyframe_path_core;
	import crk_pkg::*;

	localparam int NKEYS = 64;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	catmull_rom_keyframe_path_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// path model state
	logic [31:0] kt [NKEYS];
	logic signed [31:0] kx [NKEYS];
	logic signed [31:0] ky [NKEYS];
	logic signed [31:0] kz [NKEYS];
	int unsigned nheld = 0;
	logic [31:0] ptime = '0;
	logic pactive = 1'b0;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	bit hold_req = 1'b0;
	bit hold_done;
	int hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	task automatic add_req(input req_t q);
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	function automatic logic signed [31:0] cr_blend(input logic signed [31:0] a0,
		input logic signed [31:0] a1, input logic signed [31:0] a2,
		input logic signed [31:0] a3, input longint u);
		longint p0, p1, p2, p3, r;
		p0 = a0; p1 = a1; p2 = a2; p3 = a3;
		r = -p0 + 3 * p1 - 3 * p2 + p3;
		r = ((r * u) >>> 16) + 2 * p0 - 5 * p1 + 4 * p2 - p3;
		r = ((r * u) >>> 16) + p2 - p0;
		r = ((r * u) >>> 16) + 2 * p1;
		r = r >>> 1;
		if (r > 64'sd2147483647) return 32'sh7fffffff;
		if (r < -64'sd2147483648) return 32'sh80000000;
		return r[31:0];
	endfunction

	task automatic eval_path(input logic [31:0] t, inout rsp_t r);
		int unsigned i, im1, ip2;
		longint u;
		if (t < kt[0]) begin
			r.out_x = kx[0]; r.out_y = ky[0]; r.out_z = kz[0];
			return;
		end
		for (i = 0; i + 1 < nheld; i++)
			if (kt[i] <= t && t < kt[i + 1]) break;
		if (i + 1 >= nheld) begin
			r.out_x = kx[nheld - 1]; r.out_y = ky[nheld - 1]; r.out_z = kz[nheld - 1];
			return;
		end
		im1 = (i == 0) ? 0 : i - 1;
		ip2 = (i + 2 < nheld) ? i + 2 : nheld - 1;
		u = ({32'd0, t - kt[i]} << 16) / {32'd0, kt[i + 1] - kt[i]};
		r.out_x = cr_blend(kx[im1], kx[i], kx[i + 1], kx[ip2], u);
		r.out_y = cr_blend(ky[im1], ky[i], ky[i + 1], ky[ip2], u);
		r.out_z = cr_blend(kz[im1], kz[i], kz[i + 1], kz[ip2], u);
	endtask

	task automatic predict_path(input req_t q);
		rsp_t r;
		int unsigned i, pos;
		logic [32:0] sum;
		r = '0;
		case (q.cmd)
			CMD_INSERT: begin
				if (nheld >= NKEYS) r.status = ST_FULL;
				else begin
					pos = nheld;
					for (i = 0; i < nheld; i++)
						if (kt[i] > q.time_value) begin pos = i; break; end
					for (i = nheld; i > pos; i--) begin
						kt[i] = kt[i - 1]; kx[i] = kx[i - 1];
						ky[i] = ky[i - 1]; kz[i] = kz[i - 1];
					end
					kt[pos] = q.time_value; kx[pos] = q.key_x;
					ky[pos] = q.key_y; kz[pos] = q.key_z;
					nheld++;
				end
			end
			CMD_DELETE: begin
				if (nheld == 0) r.status = ST_EMPTY;
				else if (q.key_index >= nheld) r.status = ST_RANGE;
				else begin
					for (i = q.key_index; i + 1 < nheld; i++) begin
						kt[i] = kt[i + 1]; kx[i] = kx[i + 1];
						ky[i] = ky[i + 1]; kz[i] = kz[i + 1];
					end
					nheld--;
				end
			end
			CMD_QUERY: begin
				if (nheld == 0) r.status = ST_EMPTY;
				else begin
					eval_path(q.time_value, r);
					r.position_valid = 1'b1;
				end
			end
			CMD_START: begin
				ptime = q.time_value; pactive = 1'b1;
			end
			CMD_STOP: begin
				ptime = '0; pactive = 1'b0;
			end
			CMD_TICK: begin
				if (pactive) begin
					if (nheld == 0) begin
						pactive = 1'b0; r.status = ST_EMPTY;
					end else begin
						sum = ptime + q.time_value;
						ptime = sum[32] ? 32'hffffffff : sum[31:0];
						if (ptime > kt[nheld - 1]) begin
							ptime = '0; pactive = 1'b0;
						end else if (ptime >= kt[0]) begin
							eval_path(ptime, r);
							r.position_valid = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		r.playing = pactive;
		r.key_count = nheld[6:0];
		expected_rsps.insert(expected_rsps.size(), r);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t mk_req(input logic [2:0] c, input logic [31:0] t,
		input logic [5:0] ix);
		req_t q;
		q.cmd = c; q.time_value = t; q.key_index = ix;
		q.key_x = rand_coord(); q.key_y = rand_coord(); q.key_z = rand_coord();
		return q;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 9) < 7) begin
				in_valid <= 1'b1;
				in_data <= pending_reqs.pop_front();
			end else begin
				in_valid <= 1'b0;
				in_data <= mk_req(3'($urandom), $urandom, 6'($urandom));
			end
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && !in_stall) predict_path(in_data);

	// receiver stall, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= 400;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else case ($urandom_range(0, 19))
			0: out_stall <= 1'b1;
			1, 2, 3: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= 1'b0;
		endcase
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				errors++;
				$display("unexpected response at %0t", $realtime);
			end else begin
				e = expected_rsps.pop_front();
				if (out_data.out_x !== e.out_x) report_mismatch("out_x", out_data.out_x, e.out_x);
				if (out_data.out_y !== e.out_y) report_mismatch("out_y", out_data.out_y, e.out_y);
				if (out_data.out_z !== e.out_z) report_mismatch("out_z", out_data.out_z, e.out_z);
				if (out_data.position_valid !== e.position_valid)
					report_mismatch("position_valid", 32'(out_data.position_valid),
						32'(e.position_valid));
				if (out_data.playing !== e.playing)
					report_mismatch("playing", 32'(out_data.playing), 32'(e.playing));
				if (out_data.status !== e.status)
					report_mismatch("status", 32'(out_data.status), 32'(e.status));
				if (out_data.key_count !== e.key_count)
					report_mismatch("key_count", 32'(out_data.key_count), 32'(e.key_count));
			end
		end
	end

	initial begin
		int n, k, c, base;
		logic [31:0] t;
		arst_n = 1'b0;
		// directed: empty-store cases, extremes, equal times, playback
		add_req(mk_req(CMD_QUERY, 32'd0, 6'd0));
		add_req(mk_req(CMD_DELETE, 32'd0, 6'd0));
		add_req(mk_req(CMD_TICK, 32'd5, 6'd0));
		add_req(mk_req(CMD_START, 32'd0, 6'd0));
		add_req(mk_req(CMD_TICK, 32'd5, 6'd0));
		add_req(mk_req(CMD_INSERT, 32'h0001_0000, 6'd0));
		add_req(mk_req(CMD_INSERT, 32'h0001_0000, 6'd0));
		add_req(mk_req(CMD_INSERT, 32'h0000_0000, 6'd0));
		add_req(mk_req(CMD_INSERT, 32'hffff_ffff, 6'd0));
		add_req(mk_req(CMD_INSERT, 32'h0003_0000, 6'd0));
		add_req(mk_req(CMD_QUERY, 32'h0000_8000, 6'd0));
		add_req(mk_req(CMD_QUERY, 32'h0001_0000, 6'd0));
		add_req(mk_req(CMD_QUERY, 32'h0002_1234, 6'd0));
		add_req(mk_req(CMD_QUERY, 32'hffff_ffff, 6'd0));
		add_req(mk_req(CMD_DELETE, 32'd0, 6'd63));
		add_req(mk_req(CMD_DELETE, 32'd0, 6'd0));
		add_req(mk_req(CMD_QUERY, 32'd0, 6'd0));
		add_req(mk_req(CMD_START, 32'h0000_8000, 6'd0));
		add_req(mk_req(CMD_TICK, 32'h0000_4000, 6'd0));
		add_req(mk_req(CMD_TICK, 32'hffff_ffff, 6'd0));
		add_req(mk_req(CMD_STOP, 32'h1234, 6'd0));
		add_req(mk_req(3'd6, 32'd0, 6'd0));
		add_req(mk_req(3'd7, 32'hffff_ffff, 6'd63));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// fill the store to capacity to hit the full case
		for (k = 0; k < 66; k++)
			add_req(mk_req(CMD_INSERT, $urandom_range(0, 40) << 14, 6'd0));
		add_req(mk_req(CMD_QUERY, $urandom_range(0, 40) << 14, 6'd0));
		for (k = 0; k < 60; k++)
			add_req(mk_req(CMD_DELETE, 32'd0, 6'($urandom_range(0, 63))));
		wait (pending_reqs.size() < 40);
		hold_req = 1'b1;
		// random: mostly play sessions over a small store
		n = 0;
		while (n < 330) begin
			while (pending_reqs.size() > 8) @(posedge clk);
			c = $urandom_range(0, 9);
			base = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8) << 16;
			if (c < 3) begin
				t = base + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5) << 15);
				add_req(mk_req(CMD_INSERT, t, 6'($urandom)));
			end else if (c < 5) begin
				add_req(mk_req(CMD_QUERY,
					$urandom_range(0, 1) ? $urandom : $urandom_range(0, 10) << 15,
					6'($urandom)));
			end else if (c < 7) begin
				add_req(mk_req(CMD_START, $urandom_range(0, 4) << 15, 6'($urandom)));
				for (k = 0; k < 6; k++)
					add_req(mk_req(CMD_TICK, $urandom_range(0, 3) == 0 ?
						$urandom : $urandom_range(0, 65535), 6'($urandom)));
				n += 6;
			end else if (c < 8) begin
				add_req(mk_req(CMD_DELETE, $urandom, 6'($urandom)));
			end else if (c < 9) begin
				add_req(mk_req(CMD_STOP, $urandom, 6'($urandom)));
			end else begin
				add_req(mk_req(3'($urandom_range(0, 7)), $urandom, 6'($urandom)));
			end
			n++;
			if ($urandom_range(0, 30) == 0) repeat ($urandom_range(50, 400)) @(posedge clk);
		end
		while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
		while (expected_rsps.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
